@@ rtl/rtt_pkg.sv @@
// Shared types and constants for the retransmission tracker.
package rtt_pkg;

  localparam int unsigned FLIGHT_WINDOW_DEF = 32;
  localparam int unsigned RTO_MIN_DEF       = 100;
  localparam int unsigned RTO_MAX_DEF       = 3000;

  localparam logic [23:0] RATE_RST = 24'd5120;
  localparam logic [21:0] HIGH_RST = 22'd51200;
  localparam logic [21:0] LOW_RST  = 22'd20480;
  localparam logic [7:0]  MAXR_RST = 8'd5;
  localparam logic [15:0] SRTT_RST = 16'd100;
  localparam logic [15:0] RTO_RST  = 16'd300;
  localparam logic [21:0] BYTES_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_SCAN = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    RES_SENT      = 3'd0,
    RES_WIN_FULL  = 3'd1,
    RES_ACKED     = 3'd2,
    RES_ACK_UNK   = 3'd3,
    RES_RETRY     = 3'd4,
    RES_DROPPED   = 3'd5,
    RES_SCAN_DONE = 3'd6
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_RATE = 2'd0,
    CFG_HIGH = 2'd1,
    CFG_LOW  = 2'd2,
    CFG_MAXR = 2'd3
  } cfg_idx_t;

  // Queued request between the front and back parts.
  typedef struct packed {
    req_t        req;
    logic [31:0] now_ms;
    logic [15:0] pkt_len;
    logic [31:0] ack_seq;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  res_kind;
    logic [31:0] seq_num;
    logic [7:0]  retry_number;
    logic [31:0] next_send_ms;
    logic [15:0] rto_value_ms;
    logic [21:0] outstanding_bytes;
    logic        buffer_warning;
    logic        last_result;
  } res_t;

endpackage

@@ rtl/retransmit_tracker_with_rto.sv @@
// Top level of the retransmission tracker: configuration, front queue and back engine.
// Sequential block: a send walks the table for a free slot and then runs the bit-serial
// pacing divider; an ack walks the table, checking each valid entry, and then runs the
// RTT update; a scan checks each table entry in turn and waits while results are stalled.
// The engine starts a new request only after the previous result has been taken. A
// two-entry request queue lets new requests be accepted while the engine works;
// unknown request codes are accepted and give no result. No clearing pass follows reset.
module retransmit_tracker_with_rto #(
  parameter int unsigned FLIGHT_WINDOW = rtt_pkg::FLIGHT_WINDOW_DEF,
  parameter int unsigned RTO_MIN_MS    = rtt_pkg::RTO_MIN_DEF,
  parameter int unsigned RTO_MAX_MS    = rtt_pkg::RTO_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_pkt_len,
  input  logic [31:0] in_ack_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_res_kind,
  output logic [31:0] out_seq_num,
  output logic [7:0]  out_retry_number,
  output logic [31:0] out_next_send_ms,
  output logic [15:0] out_rto_value_ms,
  output logic [21:0] out_outstanding_bytes,
  output logic        out_buffer_warning,
  output logic        out_last_result
);
  import rtt_pkg::*;

  logic [23:0] rate_r;
  logic [21:0] high_r, low_r;
  logic [7:0]  maxr_r;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
      high_r <= HIGH_RST;
      low_r  <= LOW_RST;
      maxr_r <= MAXR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RATE: rate_r <= cfg_data;
        CFG_HIGH: high_r <= cfg_data[21:0];
        CFG_LOW:  low_r  <= cfg_data[21:0];
        CFG_MAXR: maxr_r <= cfg_data[7:0];
        default:  rate_r <= rate_r;
      endcase
    end
  end

  rtt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_now_ms(in_now_ms), .in_pkt_len(in_pkt_len),
    .in_ack_seq(in_ack_seq), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  rtt_back #(
    .FLIGHT_WINDOW(FLIGHT_WINDOW), .RTO_MIN_MS(RTO_MIN_MS), .RTO_MAX_MS(RTO_MAX_MS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .rate(rate_r), .high_water(high_r), .low_water(low_r), .max_retries(maxr_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_res_kind          = res.res_kind;
  assign out_seq_num           = res.seq_num;
  assign out_retry_number      = res.retry_number;
  assign out_next_send_ms      = res.next_send_ms;
  assign out_rto_value_ms      = res.rto_value_ms;
  assign out_outstanding_bytes = res.outstanding_bytes;
  assign out_buffer_warning    = res.buffer_warning;
  assign out_last_result       = res.last_result;

  a_rto_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rto_value_ms >= 16'(RTO_MIN_MS) || out_rto_value_ms == 16'd300))
    else $error("rto below minimum");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_kind))
    else $error("stalled result changed");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_kind == RES_SCAN_DONE |-> out_last_result)
    else $error("scan_done not last");

endmodule

@@ rtl/rtt_front.sv @@
// Front part: accepts requests, drops unknown ones, and queues the rest.
module rtt_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_req_type,
  input  logic [31:0]  in_now_ms,
  input  logic [15:0]  in_pkt_len,
  input  logic [31:0]  in_ack_seq,
  output logic         q_valid,
  output rtt_pkg::cmd_t q_cmd,
  input  logic         q_pop
);
  import rtt_pkg::*;

  // Two-entry queue.
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_req_type != REQ_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{req: req_t'(in_req_type), now_ms: in_now_ms,
                       pkt_len: in_pkt_len, ack_seq: in_ack_seq};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ rtl/rtt_div.sv @@
// Restoring divider for the pacing gap: len*1000 / rate, one quotient bit a cycle.
module rtt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [25:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [25:0] quot
);
  logic [25:0] q_r;
  logic [24:0] rem_r;
  logic [23:0] dv_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [24:0] sh;
  logic [25:0] diff;

  assign sh   = {rem_r[23:0], q_r[25]};
  assign diff = {1'b0, sh} - {2'b00, dv_r};
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        q_r    <= dividend;
        rem_r  <= '0;
        dv_r   <= divisor;
      end else if (busy_r) begin
        if (!diff[25]) begin
          rem_r <= diff[24:0];
          q_r   <= {q_r[24:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[24:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd25) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/rtt_back.sv @@
// Back part: flight table, table walks, RTT/RTO update and result register.
module rtt_back #(
  parameter int unsigned FLIGHT_WINDOW = rtt_pkg::FLIGHT_WINDOW_DEF,
  parameter int unsigned RTO_MIN_MS    = rtt_pkg::RTO_MIN_DEF,
  parameter int unsigned RTO_MAX_MS    = rtt_pkg::RTO_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  rtt_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic [23:0]   rate,
  input  logic [21:0]   high_water,
  input  logic [21:0]   low_water,
  input  logic [7:0]    max_retries,
  output logic          out_valid,
  input  logic          out_stall,
  output rtt_pkg::res_t out_res
);
  import rtt_pkg::*;

  localparam int unsigned IW = (FLIGHT_WINDOW > 1) ? $clog2(FLIGHT_WINDOW) : 1;
  localparam int unsigned CW = $clog2(FLIGHT_WINDOW + 1);
  localparam logic [15:0] RMIN = 16'(RTO_MIN_MS);
  localparam logic [15:0] RMAX = 16'(RTO_MAX_MS);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_RD, S_SEND_DIV, S_SEND_WR, S_ACK_CHK, S_RTT1, S_RTT2,
    S_SCAN_CHK, S_EMIT, S_SCAN_END
  } st_t;

  // Table fields live in a memory; valid bits are flip-flops.
  logic [31:0] seq_m  [FLIGHT_WINDOW];
  logic [31:0] time_m [FLIGHT_WINDOW];
  logic [7:0]  rtr_m  [FLIGHT_WINDOW];
  logic [15:0] len_m  [FLIGHT_WINDOW];
  logic [FLIGHT_WINDOW-1:0] valid_r;

  st_t         st_r;
  cmd_t        cmd_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] hit_r;
  logic        found_r;
  logic [31:0] rd_seq_r, rd_time_r;
  logic [7:0]  rd_rtr_r;
  logic [15:0] rd_len_r;
  logic [31:0] nseq_r;
  logic [15:0] srtt_r, rto_r, old_srtt_r;
  logic [21:0] bytes_r;
  logic        warn_r;
  logic [31:0] rtt_r;
  logic [16:0] diff_r;
  logic        mem_we;
  logic [IW-1:0] wr_a;
  logic [31:0] wr_seq, wr_time;
  logic [7:0]  wr_rtr;
  logic [15:0] wr_len;
  logic        slot_ok;
  logic        out_free;
  logic        div_start, div_done;
  logic [25:0] div_quot;
  logic [23:0] rate_eff;
  logic [34:0] s_sum;
  logic [15:0] s_new;
  logic [18:0] var_w;
  logic [20:0] rto_w;
  logic [31:0] age;
  logic [22:0] bsum;
  logic [IW-1:0] idx_a;

  assign idx_a    = idx_r[IW-1:0];
  assign out_free = !out_valid || !out_stall;
  assign rate_eff = (rate == 24'd0) ? 24'd1 : rate;
  assign age      = cmd_r.now_ms - rd_time_r;

  rtt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(26'(cmd_r.pkt_len) * 26'd1000),
    .divisor(rate_eff), .done(div_done), .quot(div_quot)
  );

  assign s_sum = 35'(old_srtt_r) * 35'd7 + 35'(rtt_r);
  assign s_new = (s_sum[34:3] > 32'd65535) ? 16'hFFFF : s_sum[18:3];
  assign var_w = 19'((19'(srtt_r) * 19'd3 + 19'(diff_r)) >> 2);
  assign rto_w = 21'(srtt_r) + {var_w, 2'b00};

  always_comb begin
    slot_ok   = 1'b0;
    // Take a new request only once the previous result has left.
    q_pop     = (st_r == S_IDLE) && q_valid && out_free;
    mem_we    = 1'b0;
    wr_a      = hit_r;
    wr_seq    = rd_seq_r;
    wr_time   = rd_time_r;
    wr_rtr    = rd_rtr_r;
    wr_len    = rd_len_r;
    bsum      = 23'(bytes_r) + 23'(cmd_r.pkt_len);
    if (st_r == S_SEND_DIV && div_done) begin
      mem_we  = 1'b1;
      wr_seq  = nseq_r;
      wr_time = cmd_r.now_ms;
      wr_rtr  = 8'd0;
      wr_len  = cmd_r.pkt_len;
    end
    if (st_r == S_SCAN_CHK && out_free && valid_r[idx_a] && age > 32'(rto_r) &&
        rd_rtr_r < max_retries) begin
      mem_we  = 1'b1;
      wr_a    = idx_a;
      wr_time = cmd_r.now_ms;
      wr_rtr  = rd_rtr_r + 8'd1;
    end
    if (st_r == S_WALK && idx_r < CW'(FLIGHT_WINDOW) && !valid_r[idx_a]) slot_ok = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_m[wr_a]  <= wr_seq;
      time_m[wr_a] <= wr_time;
      rtr_m[wr_a]  <= wr_rtr;
      len_m[wr_a]  <= wr_len;
    end
    rd_seq_r  <= seq_m[idx_a];
    rd_time_r <= time_m[idx_a];
    rd_rtr_r  <= rtr_m[idx_a];
    rd_len_r  <= len_m[idx_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      valid_r   <= '0;
      nseq_r    <= '0;
      srtt_r    <= SRTT_RST;
      rto_r     <= RTO_RST;
      bytes_r   <= '0;
      warn_r    <= 1'b0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      hit_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid && out_free) begin
            cmd_r   <= q_cmd;
            idx_r   <= '0;
            found_r <= 1'b0;
            st_r    <= (q_cmd.req == REQ_SCAN) ? S_RD : S_WALK;
          end
        end
        S_WALK: begin
          // Send looks for a free slot; ack checks each valid entry in order.
          if (idx_r == CW'(FLIGHT_WINDOW)) begin
            if (cmd_r.req == REQ_SEND) begin
              out_res <= '{RES_WIN_FULL, nseq_r, 8'd0, 32'd0, rto_r, bytes_r,
                           warn_r, 1'b1};
            end else begin
              out_res <= '{RES_ACK_UNK, cmd_r.ack_seq, 8'd0, 32'd0, rto_r, bytes_r,
                           warn_r, 1'b1};
            end
            st_r <= S_EMIT;
          end else if (cmd_r.req == REQ_SEND) begin
            if (slot_ok) begin
              hit_r <= idx_a;
              st_r  <= S_SEND_DIV;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end else if (valid_r[idx_a]) begin
            hit_r <= idx_a;
            st_r  <= S_ACK_CHK;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_SEND_DIV: begin
          if (div_done) begin
            valid_r[hit_r] <= 1'b1;
            nseq_r  <= nseq_r + 32'd1;
            bytes_r <= bsum[22] ? BYTES_MAX : bsum[21:0];
            if ((bsum[22] ? BYTES_MAX : bsum[21:0]) > high_water) warn_r <= 1'b1;
            out_res <= '{RES_SENT, nseq_r, 8'd0,
                         cmd_r.now_ms + ((div_quot == 26'd0) ? 32'd1 : 32'(div_quot)),
                         rto_r, bsum[22] ? BYTES_MAX : bsum[21:0],
                         ((bsum[22] ? BYTES_MAX : bsum[21:0]) > high_water) | warn_r,
                         1'b1};
            st_r <= S_EMIT;
          end
        end
        S_ACK_CHK: begin
          if (rd_seq_r == cmd_r.ack_seq) begin
            rtt_r      <= cmd_r.now_ms - rd_time_r;
            old_srtt_r <= srtt_r;
            st_r       <= S_RTT1;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r  <= S_WALK;
          end
        end
        S_RTT1: begin
          if (rtt_r != 32'd0) begin
            srtt_r <= s_new;
            diff_r <= (rtt_r >= 32'(old_srtt_r)) ?
                      ((rtt_r - 32'(old_srtt_r)) > 32'h1FFFF ? 17'h1FFFF
                       : 17'(rtt_r - 32'(old_srtt_r)))
                      : 17'(old_srtt_r - 16'(rtt_r));
            st_r <= S_RTT2;
          end else begin
            st_r <= S_RTT2;
            found_r <= 1'b1;
          end
        end
        S_RTT2: begin
          if (!found_r) begin
            if (rto_w < 21'(RMIN)) rto_r <= RMIN;
            else if (rto_w > 21'(RMAX)) rto_r <= (RMAX < RMIN) ? RMIN : RMAX;
            else rto_r <= rto_w[15:0];
          end
          valid_r[hit_r] <= 1'b0;
          bytes_r <= (22'(rd_len_r) > bytes_r) ? 22'd0 : bytes_r - 22'(rd_len_r);
          out_res <= '{RES_ACKED, cmd_r.ack_seq, rd_rtr_r, 32'd0,
                       found_r ? rto_r :
                       ((rto_w < 21'(RMIN)) ? RMIN :
                        (rto_w > 21'(RMAX)) ? ((RMAX < RMIN) ? RMIN : RMAX) : rto_w[15:0]),
                       (22'(rd_len_r) > bytes_r) ? 22'd0 : bytes_r - 22'(rd_len_r),
                       warn_r, 1'b1};
          st_r <= S_EMIT;
        end
        S_RD: begin
          // Wait for the registered table read.
          if (idx_r == CW'(FLIGHT_WINDOW)) st_r <= S_SCAN_END;
          else st_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (out_free) begin
            if (valid_r[idx_a] && age > 32'(rto_r)) begin
              if (rd_rtr_r < max_retries) begin
                out_res <= '{RES_RETRY, rd_seq_r, rd_rtr_r + 8'd1, 32'd0, rto_r,
                             bytes_r, warn_r, 1'b0};
              end else begin
                valid_r[idx_a] <= 1'b0;
                bytes_r <= (22'(rd_len_r) > bytes_r) ? 22'd0 : bytes_r - 22'(rd_len_r);
                out_res <= '{RES_DROPPED, rd_seq_r, rd_rtr_r, 32'd0, rto_r,
                             (22'(rd_len_r) > bytes_r) ? 22'd0 : bytes_r - 22'(rd_len_r),
                             warn_r, 1'b0};
              end
              out_valid <= 1'b1;
            end
            idx_r <= idx_r + CW'(1);
            st_r  <= S_RD;
          end
        end
        S_SCAN_END: begin
          if (out_free) begin
            if (warn_r && bytes_r < low_water) warn_r <= 1'b0;
            out_res <= '{RES_SCAN_DONE, 32'd0, 8'd0, 32'd0, rto_r, bytes_r,
                         warn_r && !(bytes_r < low_water), 1'b1};
            out_valid <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_WALK && cmd_r.req == REQ_SEND && slot_ok &&
          idx_r != CW'(FLIGHT_WINDOW)) begin
        found_r <= 1'b0;
      end
    end
  end

  // Start the divider when a free slot is found.
  always_ff @(posedge clk) begin
    if (!rst_n) div_start <= 1'b0;
    else div_start <= (st_r == S_WALK) && (cmd_r.req == REQ_SEND) && slot_ok &&
                      (idx_r != CW'(FLIGHT_WINDOW));
  end

endmodule
